/* hw/rtl/address_registration_table_assert.svh */
// Assertion macros for the address registration table sequencer.
`ifndef ADDRESS_REGISTRATION_TABLE_ASSERT_SVH
`define ADDRESS_REGISTRATION_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define ART_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("address registration table: check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define ART_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("address registration table: check failed");
`else
`define ART_ASSERT_IMPL(lbl, ante, cons)
`define ART_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/art_pkg.sv */
// Types, codes and defaults of the address registration table.
package art_pkg;

	// Default sizes
	localparam int DEF_TABLE_ENTRIES = 8;
	localparam int DEF_ROUTER_COUNT  = 4;

	// Operation codes
	localparam logic [2:0] OP_ADD        = 3'd0;
	localparam logic [2:0] OP_REMOVE     = 3'd1;
	localparam logic [2:0] OP_LOOKUP     = 3'd2;
	localparam logic [2:0] OP_PURGE_RTR  = 3'd3;
	localparam logic [2:0] OP_PURGE_ADDR = 3'd4;
	localparam logic [2:0] OP_COUNT      = 3'd5;

	// Registration states
	localparam logic [1:0] RS_GC         = 2'd0;
	localparam logic [1:0] RS_TENTATIVE  = 2'd1;
	localparam logic [1:0] RS_REGISTERED = 2'd2;
	localparam logic [1:0] RS_UNREGISTER = 2'd3;

	// Configuration register indexes and reset value
	localparam logic       REG_GC_LIFETIME   = 1'b0;
	localparam logic       REG_TENT_LIFETIME = 1'b1;
	localparam logic [15:0] LIFETIME_RESET   = 16'd20;

	// One table entry as stored in memory
	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [1:0]  router;
		logic [1:0]  state;
		logic [15:0] lifetime;
		logic [63:0] mac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Flags from the compare unit
	typedef struct packed {
		logic addr_eq;
		logic rtr_eq;
		logic is_gc;
		logic is_reg;
	} match_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

endpackage

/* hw/rtl/art_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/art_match.sv */
// Shared compare unit: checks one stored entry against the request key.
module art_match (
	input  art_pkg::entry_t ent,
	input  logic [63:0]     key_hi,
	input  logic [63:0]     key_lo,
	input  logic [1:0]      key_rtr,
	output art_pkg::match_t flags
);

	// Compare address, router and state
	always_comb begin
		flags.addr_eq = (ent.addr_hi == key_hi) && (ent.addr_lo == key_lo);
		flags.rtr_eq  = (ent.router == key_rtr);
		flags.is_gc   = (ent.state == art_pkg::RS_GC);
		flags.is_reg  = (ent.state == art_pkg::RS_REGISTERED);
	end

endmodule

/* hw/rtl/art_seq.sv */
// Sequencer: scans the table one entry a cycle through the compare unit.
module art_seq #(
	parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES,
	parameter int ROUTER_COUNT  = art_pkg::DEF_ROUTER_COUNT,
	parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic [2:0]                  op,
	input  logic [63:0]                 addr_hi,
	input  logic [63:0]                 addr_lo,
	input  logic [1:0]                  router,
	input  logic                        router_valid,
	input  logic [1:0]                  reg_state,
	input  logic [15:0]                 lifetime,
	input  logic [63:0]                 mac,
	input  logic [2:0]                  slot,
	input  logic [15:0]                 gc_life,
	input  logic [15:0]                 tent_life,
	output logic                        hit,
	output logic [2:0]                  slot_out,
	output logic [1:0]                  found_state,
	output logic [15:0]                 found_lifetime,
	output logic [63:0]                 found_mac,
	output logic [7:0]                  router_count,
	output logic                        ram_we,
	output logic [IW-1:0]               ram_waddr,
	output logic [art_pkg::ENTRY_W-1:0] ram_wdata,
	output logic                        ram_re,
	output logic [IW-1:0]               ram_raddr,
	input  logic [art_pkg::ENTRY_W-1:0] ram_rdata
);

	`include "address_registration_table_assert.svh"

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = (ROUTER_COUNT > 1) ? $clog2(ROUTER_COUNT) : 1;

	art_pkg::state_t state_q, state_d;

	// Control state
	logic            used_q [TABLE_ENTRIES];
	logic [7:0]      cnt_q  [ROUTER_COUNT];
	logic            pend_s1;
	logic [IW-1:0]   pidx_s1;
	logic [CW-1:0]   iss_q;
	logic [IW-1:0]   last_q;
	logic            have_q;
	logic [IW-1:0]   pick_q;

	// Captured request
	logic [2:0]      op_q;
	logic [63:0]     key_hi_q;
	logic [63:0]     key_lo_q;
	logic [1:0]      rtr_q;
	logic            rvalid_q;
	logic            rok_q;
	logic [1:0]      rstate_q;
	logic [15:0]     life_q;
	logic [63:0]     mac_q;

	// Result
	logic            hit_q;
	logic [2:0]      slot_q;
	logic [1:0]      fstate_q;
	logic [15:0]     flife_q;
	logic [63:0]     fmac_q;

	// Combinational decisions
	art_pkg::entry_t ent;
	art_pkg::entry_t marked;
	art_pkg::entry_t new_ent;
	art_pkg::match_t mf;
	logic            accept;
	logic            rok_in;
	logic            scan_in;
	logic [CW-1:0]   first_in;
	logic [IW-1:0]   last_in;
	logic [15:0]     life_in;
	logic            issue;
	logic            eval;
	logic            u;
	logic            take_pick;
	logic            stop_now;
	logic            do_drop;
	logic            do_mark;
	logic            do_hit;
	logic            leave;
	logic            do_add;
	logic            dr_ok;
	logic [RW-1:0]   dr_idx;
	logic [RW-1:0]   rt_idx;

	art_match u_match (
		.ent     (ent),
		.key_hi  (key_hi_q),
		.key_lo  (key_lo_q),
		.key_rtr (rtr_q),
		.flags   (mf)
	);

	assign busy   = (state_q != art_pkg::ST_IDLE);
	assign done   = (state_q == art_pkg::ST_RESP);
	assign accept = start && !busy;
	assign rok_in = (32'(router) < ROUTER_COUNT);
	assign rt_idx = RW'(rtr_q);

	// Decode the request at accept: scan range and stored lifetime
	always_comb begin
		scan_in  = 1'b0;
		first_in = '0;
		last_in  = IW'(TABLE_ENTRIES - 1);
		case (op)
			art_pkg::OP_ADD:        scan_in = rok_in;
			art_pkg::OP_LOOKUP:     scan_in = rok_in;
			art_pkg::OP_PURGE_RTR:  scan_in = rok_in;
			art_pkg::OP_PURGE_ADDR: scan_in = 1'b1;
			art_pkg::OP_REMOVE: begin
				scan_in  = (32'(slot) < TABLE_ENTRIES);
				first_in = CW'(slot);
				last_in  = IW'(slot);
			end
			default: scan_in = 1'b0;
		endcase
		case (reg_state)
			art_pkg::RS_GC:        life_in = gc_life;
			art_pkg::RS_TENTATIVE: life_in = tent_life;
			default:               life_in = lifetime;
		endcase
	end

	// Evaluate the entry read in the previous cycle
	always_comb begin
		ent       = art_pkg::entry_t'(ram_rdata);
		u         = used_q[pidx_s1];
		issue     = (state_q == art_pkg::ST_SCAN) && (iss_q <= CW'(last_q));
		eval      = (state_q == art_pkg::ST_SCAN) && pend_s1;
		take_pick = 1'b0;
		stop_now  = 1'b0;
		do_drop   = 1'b0;
		do_mark   = 1'b0;
		do_hit    = 1'b0;
		if (eval) begin
			case (op_q)
				art_pkg::OP_ADD: begin
					if (!u) begin
						take_pick = 1'b1;
						stop_now  = 1'b1;
					end else if (mf.is_gc) begin
						take_pick = 1'b1;
					end
				end
				art_pkg::OP_REMOVE: do_drop = u;
				art_pkg::OP_LOOKUP: begin
					if (u && mf.addr_eq && mf.rtr_eq) begin
						do_hit   = 1'b1;
						stop_now = 1'b1;
					end
				end
				art_pkg::OP_PURGE_RTR: do_drop = u && mf.rtr_eq;
				art_pkg::OP_PURGE_ADDR: begin
					if (u && mf.addr_eq) begin
						if (mf.is_reg) begin
							do_mark = 1'b1;
						end else begin
							do_drop = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		leave  = eval && (stop_now || (pidx_s1 == last_q));
		dr_ok  = (32'(ent.router) < ROUTER_COUNT);
		dr_idx = RW'(ent.router);
	end

	// Memory port: issue scan reads; demote a registered entry, or store the added one
	always_comb begin
		marked           = ent;
		marked.state     = art_pkg::RS_UNREGISTER;
		new_ent.addr_hi  = key_hi_q;
		new_ent.addr_lo  = key_lo_q;
		new_ent.router   = rtr_q;
		new_ent.state    = rstate_q;
		new_ent.lifetime = life_q;
		new_ent.mac      = mac_q;
		do_add    = (state_q == art_pkg::ST_WRITE) && (op_q == art_pkg::OP_ADD) && have_q;
		ram_we    = do_mark || do_add;
		ram_waddr = do_mark ? pidx_s1 : pick_q;
		ram_wdata = do_mark ? marked : new_ent;
		ram_re    = issue;
		ram_raddr = iss_q[IW-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			art_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = scan_in ? art_pkg::ST_SCAN : art_pkg::ST_RESP;
				end
			end
			art_pkg::ST_SCAN:  if (leave) state_d = art_pkg::ST_WRITE;
			art_pkg::ST_WRITE: state_d = art_pkg::ST_RESP;
			art_pkg::ST_RESP:  state_d = art_pkg::ST_IDLE;
			default:           state_d = art_pkg::ST_IDLE;
		endcase
	end

	// Control registers: state, scan pointer, used bits, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= art_pkg::ST_IDLE;
			pend_s1 <= 1'b0;
			iss_q   <= '0;
			have_q  <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				used_q[i] <= 1'b0;
			end
			for (int i = 0; i < ROUTER_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pend_s1 <= issue && !leave;
			if (accept) begin
				iss_q  <= first_in;
				have_q <= 1'b0;
			end else if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (take_pick) begin
				have_q <= 1'b1;
			end
			// drop an entry and count its router down
			if (do_drop) begin
				used_q[pidx_s1] <= 1'b0;
				if (dr_ok) begin
					cnt_q[dr_idx] <= cnt_q[dr_idx] - 8'd1;
				end
			end
			// place the new entry and count its router up
			if (do_add) begin
				used_q[pick_q] <= 1'b1;
				cnt_q[rt_idx]  <= cnt_q[rt_idx] + 8'd1;
			end
		end
	end

	// Payload registers: request, scan stage index, result
	always_ff @(posedge clk) begin
		if (issue) begin
			pidx_s1 <= iss_q[IW-1:0];
		end
		if (take_pick) begin
			pick_q <= pidx_s1;
		end
		if (accept) begin
			op_q     <= op;
			key_hi_q <= addr_hi;
			key_lo_q <= addr_lo;
			rtr_q    <= router;
			rvalid_q <= router_valid;
			rok_q    <= rok_in;
			rstate_q <= reg_state;
			life_q   <= life_in;
			mac_q    <= mac;
			last_q   <= last_in;
			hit_q    <= 1'b0;
			slot_q   <= '0;
			fstate_q <= '0;
			flife_q  <= '0;
			fmac_q   <= '0;
		end
		if (do_hit) begin
			hit_q    <= 1'b1;
			slot_q   <= 3'(pidx_s1);
			fstate_q <= ent.state;
			flife_q  <= ent.lifetime;
			fmac_q   <= ent.mac;
		end
		if (do_add) begin
			hit_q    <= 1'b1;
			slot_q   <= 3'(pick_q);
			fstate_q <= rstate_q;
			flife_q  <= life_q;
			fmac_q   <= mac_q;
		end
	end

	// Drive the result transfer
	assign hit            = hit_q;
	assign slot_out       = slot_q;
	assign found_state    = fstate_q;
	assign found_lifetime = flife_q;
	assign found_mac      = fmac_q;
	assign router_count   = (rvalid_q && rok_q) ? cnt_q[rt_idx] : 8'd0;

	// Checks
	`ART_ASSERT_NEXT(a_accept_busy, accept, busy)
	`ART_ASSERT_NEXT(a_done_pulse, done, !done)
	`ART_ASSERT_IMPL(a_hit_op, done && hit, op_q == art_pkg::OP_ADD || op_q == art_pkg::OP_LOOKUP)
	`ART_ASSERT_IMPL(a_pend_scan, pend_s1, state_q == art_pkg::ST_SCAN)

endmodule

/* hw/rtl/address_registration_table.sv */
// Top level of the address registration table: config port, table memory, sequencer.
//
// Channel   Direction  Handshake                       Payload
// request   in         start && !busy                  op, addr_hi, addr_lo, router, ...
// result    out        done, one cycle, no stall       hit, slot_out, found_*, router_count
// config    in         psel && penable && pwrite       paddr, pwdata (prdata on read)
//
// Add, lookup and the purges scan the table, one scan read a cycle from the table
// memory; add stops at the first free slot and lookup at the first match. Remove reads
// only its own slot, and any other item goes straight to the result.
// busy holds through the done cycle, so a new transfer is taken in the cycle after done at best.
// Reset clears the used bits and router counters at once; no clearing pass.
// The receiver cannot stall: done marks a result for exactly one cycle.
module address_registration_table #(
	parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES,
	parameter int ROUTER_COUNT  = art_pkg::DEF_ROUTER_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic [1:0]  router,
	input  logic        router_valid,
	input  logic [1:0]  reg_state,
	input  logic [15:0] lifetime,
	input  logic [63:0] mac,
	input  logic [2:0]  slot,
	output logic        done,
	output logic        hit,
	output logic [2:0]  slot_out,
	output logic [1:0]  found_state,
	output logic [15:0] found_lifetime,
	output logic [63:0] found_mac,
	output logic [7:0]  router_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [15:0] gc_life_q;
	logic [15:0] tent_life_q;
	logic        cfg_wr;

	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;
	logic [art_pkg::ENTRY_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [IW-1:0]               ram_raddr;
	logic [art_pkg::ENTRY_W-1:0] ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Take a configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_life_q   <= art_pkg::LIFETIME_RESET;
			tent_life_q <= art_pkg::LIFETIME_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == art_pkg::REG_GC_LIFETIME) begin
				gc_life_q <= pwdata[15:0];
			end else begin
				tent_life_q <= pwdata[15:0];
			end
		end
	end

	// Return register contents on read
	assign prdata = (paddr[2] == art_pkg::REG_GC_LIFETIME) ? {16'd0, gc_life_q}
	                                                       : {16'd0, tent_life_q};

	art_ram #(
		.WIDTH (art_pkg::ENTRY_W),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	art_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ROUTER_COUNT  (ROUTER_COUNT),
		.IW            (IW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.done           (done),
		.op             (op),
		.addr_hi        (addr_hi),
		.addr_lo        (addr_lo),
		.router         (router),
		.router_valid   (router_valid),
		.reg_state      (reg_state),
		.lifetime       (lifetime),
		.mac            (mac),
		.slot           (slot),
		.gc_life        (gc_life_q),
		.tent_life      (tent_life_q),
		.hit            (hit),
		.slot_out       (slot_out),
		.found_state    (found_state),
		.found_lifetime (found_lifetime),
		.found_mac      (found_mac),
		.router_count   (router_count),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the address registration table.
module tb_top;

	localparam int ENTRIES = art_pkg::DEF_TABLE_ENTRIES;
	localparam int ROUTERS = art_pkg::DEF_ROUTER_COUNT;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 310;
	localparam int SETTLE = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;
	localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] A1_HI = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] A1_LO = 64'hFEDC_BA98_7654_3210;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [1:0]  router;
		logic        router_valid;
		logic [1:0]  reg_state;
		logic [15:0] lifetime;
		logic [63:0] mac;
		logic [2:0]  slot;
	} request_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  slot_out;
		logic [1:0]  found_state;
		logic [15:0] found_lifetime;
		logic [63:0] found_mac;
		logic [7:0]  router_count;
	} outcome_t;

	typedef struct {
		request_t req;
		bit       typed;
		outcome_t want;
	} vector_t;

	localparam outcome_t NONE = '0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  op;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [1:0]  router;
	logic        router_valid;
	logic [1:0]  reg_state;
	logic [15:0] lifetime;
	logic [63:0] mac;
	logic [2:0]  slot;
	logic        done;
	logic        hit;
	logic [2:0]  slot_out;
	logic [1:0]  found_state;
	logic [15:0] found_lifetime;
	logic [63:0] found_mac;
	logic [7:0]  router_count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the table, the router counters and the lifetime registers
	logic       tbl_used [ENTRIES];
	art_pkg::entry_t tbl_entry [ENTRIES];
	logic [7:0] rtr_regs [ROUTERS];
	logic [15:0] cfg_gc_life;
	logic [15:0] cfg_tent_life;

	outcome_t   pending[$];
	vector_t    vectors[$];
	logic [127:0] addr_pool [6];
	outcome_t   mon_want;
	int         errors;
	int         sent;
	int         cycles;
	bit         no_idle;

	address_registration_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.addr_hi(addr_hi),
		.addr_lo(addr_lo),
		.router(router),
		.router_valid(router_valid),
		.reg_state(reg_state),
		.lifetime(lifetime),
		.mac(mac),
		.slot(slot),
		.done(done),
		.hit(hit),
		.slot_out(slot_out),
		.found_state(found_state),
		.found_lifetime(found_lifetime),
		.found_mac(found_mac),
		.router_count(router_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Bound the run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("FAIL address_registration_table");
			$finish;
		end
	end

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	// Remove one entry and drop its router's counter
	function automatic void drop_entry(int s);
		if (int'(tbl_entry[s].router) < ROUTERS)
			rtr_regs[tbl_entry[s].router] = rtr_regs[tbl_entry[s].router] - 8'd1;
		tbl_used[s] = 1'b0;
	endfunction

	function automatic outcome_t report_entry(int s);
		outcome_t o;
		o = '0;
		o.hit = 1'b1;
		o.slot_out = s[2:0];
		o.found_state = tbl_entry[s].state;
		o.found_lifetime = tbl_entry[s].lifetime;
		o.found_mac = tbl_entry[s].mac;
		return o;
	endfunction

	// Apply one operation to the shadow table and return its result
	function automatic outcome_t registration_step(request_t q);
		outcome_t o;
		bit rok;
		bit have;
		bit free_found;
		bit matched;
		int pick;
		o = '0;
		rok = int'(q.router) < ROUTERS;
		have = 1'b0;
		free_found = 1'b0;
		matched = 1'b0;
		pick = 0;
		case (q.op)
			art_pkg::OP_ADD: begin
				if (rok) begin
					for (int s = 0; s < ENTRIES; s++) begin
						if (!free_found) begin
							if (!tbl_used[s]) begin
								pick = s;
								have = 1'b1;
								free_found = 1'b1;
							end else if (tbl_entry[s].state == art_pkg::RS_GC) begin
								pick = s;
								have = 1'b1;
							end
						end
					end
					if (have) begin
						tbl_used[pick] = 1'b1;
						tbl_entry[pick].addr_hi = q.addr_hi;
						tbl_entry[pick].addr_lo = q.addr_lo;
						tbl_entry[pick].router = q.router;
						tbl_entry[pick].state = q.reg_state;
						tbl_entry[pick].mac = q.mac;
						if (q.reg_state == art_pkg::RS_GC)
							tbl_entry[pick].lifetime = cfg_gc_life;
						else if (q.reg_state == art_pkg::RS_TENTATIVE)
							tbl_entry[pick].lifetime = cfg_tent_life;
						else
							tbl_entry[pick].lifetime = q.lifetime;
						rtr_regs[q.router] = rtr_regs[q.router] + 8'd1;
						o = report_entry(pick);
					end
				end
			end
			art_pkg::OP_REMOVE: begin
				if (int'(q.slot) < ENTRIES && tbl_used[q.slot])
					drop_entry(int'(q.slot));
			end
			art_pkg::OP_LOOKUP: begin
				if (rok) begin
					for (int s = 0; s < ENTRIES; s++) begin
						if (!matched && tbl_used[s] && tbl_entry[s].addr_hi == q.addr_hi &&
								tbl_entry[s].addr_lo == q.addr_lo &&
								tbl_entry[s].router == q.router) begin
							o = report_entry(s);
							matched = 1'b1;
						end
					end
				end
			end
			art_pkg::OP_PURGE_RTR: begin
				if (rok) begin
					for (int s = 0; s < ENTRIES; s++)
						if (tbl_used[s] && tbl_entry[s].router == q.router)
							drop_entry(s);
				end
			end
			art_pkg::OP_PURGE_ADDR: begin
				for (int s = 0; s < ENTRIES; s++) begin
					if (tbl_used[s] && tbl_entry[s].addr_hi == q.addr_hi &&
							tbl_entry[s].addr_lo == q.addr_lo) begin
						if (tbl_entry[s].state != art_pkg::RS_REGISTERED)
							drop_entry(s);
						else
							tbl_entry[s].state = art_pkg::RS_UNREGISTER;
					end
				end
			end
			default: ;
		endcase
		if (q.router_valid && rok)
			o.router_count = rtr_regs[q.router];
		return o;
	endfunction

	function automatic request_t mk_req(logic [2:0] o, logic [63:0] ah, logic [63:0] al,
			logic [1:0] r, logic rv, logic [1:0] st, logic [15:0] lf, logic [63:0] m,
			logic [2:0] sl);
		request_t q;
		q.op = o;
		q.addr_hi = ah;
		q.addr_lo = al;
		q.router = r;
		q.router_valid = rv;
		q.reg_state = st;
		q.lifetime = lf;
		q.mac = m;
		q.slot = sl;
		return q;
	endfunction

	function automatic outcome_t mk_out(logic h, logic [2:0] s, logic [1:0] st,
			logic [15:0] lf, logic [63:0] m, logic [7:0] cnt);
		outcome_t o;
		o.hit = h;
		o.slot_out = s;
		o.found_state = st;
		o.found_lifetime = lf;
		o.found_mac = m;
		o.router_count = cnt;
		return o;
	endfunction

	function automatic void add_row(request_t q, bit typed, outcome_t want);
		vector_t v;
		v.req = q;
		v.typed = typed;
		v.want = want;
		vectors.push_back(v);
	endfunction

	// Mostly short gaps, a few long ones, none during a no-idle stretch
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic request_t random_request();
		request_t q;
		logic [127:0] a;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			q.op = art_pkg::OP_ADD;
		else if (r < 50)
			q.op = art_pkg::OP_REMOVE;
		else if (r < 68)
			q.op = art_pkg::OP_LOOKUP;
		else if (r < 73)
			q.op = art_pkg::OP_PURGE_RTR;
		else if (r < 83)
			q.op = art_pkg::OP_PURGE_ADDR;
		else if (r < 95)
			q.op = art_pkg::OP_COUNT;
		else
			q.op = r[0] ? OP_UNUSED7 : OP_UNUSED6;
		if ($urandom_range(0, 99) < 80)
			a = addr_pool[$urandom_range(0, 5)];
		else
			a = {$urandom, $urandom, $urandom, $urandom};
		q.addr_hi = a[127:64];
		q.addr_lo = a[63:0];
		q.router = 2'($urandom_range(0, 3));
		q.router_valid = ($urandom_range(0, 3) != 0);
		q.reg_state = 2'($urandom_range(0, 3));
		q.lifetime = 16'($urandom);
		q.mac = {$urandom, $urandom};
		q.slot = 3'($urandom_range(0, 7));
		return q;
	endfunction

	// Present one request and hold it until the transfer; queue its result
	task automatic issue(request_t q, bit typed, outcome_t want, int gap);
		outcome_t pred;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= q.op;
		addr_hi <= q.addr_hi;
		addr_lo <= q.addr_lo;
		router <= q.router;
		router_valid <= q.router_valid;
		reg_state <= q.reg_state;
		lifetime <= q.lifetime;
		mac <= q.mac;
		slot <= q.slot;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = registration_step(q);
		pending.push_back(typed ? want : pred);
		sent++;
	endtask

	task automatic send(request_t q);
		issue(q, 1'b0, NONE, pick_gap());
	endtask

	// Stop issuing and wait until every result is back and the block is quiet
	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one lifetime register, then read it back
	task automatic write_cfg(logic idx, logic [15:0] val);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == art_pkg::REG_GC_LIFETIME)
			cfg_gc_life = val;
		else
			cfg_tent_life = val;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("prdata", {48'h0, val}, {32'h0, rd});
	endtask

	// Add, look up, then often purge the same address or remove a random slot
	task automatic run_session();
		request_t q;
		int r;
		q = random_request();
		q.op = art_pkg::OP_ADD;
		send(q);
		q.op = art_pkg::OP_LOOKUP;
		q.router_valid = 1'($urandom_range(0, 1));
		send(q);
		r = $urandom_range(0, 9);
		if (r < 3) begin
			q.op = art_pkg::OP_PURGE_ADDR;
			send(q);
		end else if (r < 5) begin
			q.op = art_pkg::OP_REMOVE;
			send(q);
		end
	endtask

	// Drive one router's counter up past 255 and then back down past zero
	task automatic wrap_counter();
		request_t q;
		int k;
		q = random_request();
		q.router_valid = 1'b1;
		for (int r = 0; r < ROUTERS; r++) begin
			q.op = art_pkg::OP_PURGE_RTR;
			q.router = 2'(r);
			send(q);
		end
		k = (250 - int'(rtr_regs[3])) & 255;
		if (k < 16)
			k += 256;
		for (int i = 0; i < ENTRIES + k; i++) begin
			q = random_request();
			q.op = art_pkg::OP_ADD;
			q.router = 2'd3;
			q.reg_state = art_pkg::RS_GC;
			send(q);
		end
		for (int s = 0; s < ENTRIES; s++) begin
			q.op = art_pkg::OP_REMOVE;
			q.slot = 3'(s);
			q.router_valid = 1'b1;
			send(q);
		end
	endtask

	// Check every result against the oldest outstanding expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%0t: result with nothing outstanding, hit %b slot %0d count %0d",
					$time, hit, slot_out, router_count);
				errors++;
			end else begin
				mon_want = pending.pop_front();
				check_field("hit", 64'(mon_want.hit), 64'(hit));
				check_field("slot_out", 64'(mon_want.slot_out), 64'(slot_out));
				check_field("found_state", 64'(mon_want.found_state), 64'(found_state));
				check_field("found_lifetime", 64'(mon_want.found_lifetime),
					64'(found_lifetime));
				check_field("found_mac", mon_want.found_mac, found_mac);
				check_field("router_count", 64'(mon_want.router_count), 64'(router_count));
			end
		end
	end

	initial begin : main
		request_t q;
		int phase_start;
		errors = 0;
		sent = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = art_pkg::OP_COUNT;
		addr_hi = '0;
		addr_lo = '0;
		router = '0;
		router_valid = 1'b0;
		reg_state = art_pkg::RS_GC;
		lifetime = '0;
		mac = '0;
		slot = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_gc_life = art_pkg::LIFETIME_RESET;
		cfg_tent_life = art_pkg::LIFETIME_RESET;
		for (int s = 0; s < ENTRIES; s++) begin
			tbl_used[s] = 1'b0;
			tbl_entry[s] = '0;
		end
		for (int r = 0; r < ROUTERS; r++)
			rtr_regs[r] = 8'd0;

		// Directed rows: empty-table queries, unknown ops, one add per state,
		// purge by address on registered and other states, full-table overwrite
		add_row(mk_req(art_pkg::OP_COUNT, 0, 0, 0, 1, art_pkg::RS_GC, 0, 0, 0), 1, NONE);
		add_row(mk_req(art_pkg::OP_COUNT, ALL1, ALL1, 3, 0, art_pkg::RS_UNREGISTER,
			16'hFFFF, ALL1, 7), 1, NONE);
		add_row(mk_req(art_pkg::OP_REMOVE, 0, 0, 3, 1, art_pkg::RS_GC, 0, 0, 7), 1, NONE);
		add_row(mk_req(art_pkg::OP_LOOKUP, ALL1, ALL1, 3, 1, art_pkg::RS_GC, 0, 0, 0), 1,
			NONE);
		add_row(mk_req(OP_UNUSED6, 0, 0, 2, 1, art_pkg::RS_GC, 0, 0, 0), 1, NONE);
		add_row(mk_req(OP_UNUSED7, ALL1, ALL1, 3, 1, art_pkg::RS_UNREGISTER, 16'hFFFF, ALL1,
			7), 1, NONE);
		add_row(mk_req(art_pkg::OP_ADD, 0, 0, 0, 1, art_pkg::RS_GC, 16'hFFFF, ALL1, 0), 1,
			mk_out(1, 0, art_pkg::RS_GC, art_pkg::LIFETIME_RESET, ALL1, 1));
		add_row(mk_req(art_pkg::OP_ADD, ALL1, ALL1, 1, 1, art_pkg::RS_TENTATIVE, 0, 0, 0), 1,
			mk_out(1, 1, art_pkg::RS_TENTATIVE, art_pkg::LIFETIME_RESET, 0, 1));
		add_row(mk_req(art_pkg::OP_ADD, A1_HI, A1_LO, 2, 1, art_pkg::RS_REGISTERED, 16'hFFFF,
			64'h5555, 0), 1, mk_out(1, 2, art_pkg::RS_REGISTERED, 16'hFFFF, 64'h5555, 1));
		add_row(mk_req(art_pkg::OP_ADD, A1_HI, A1_LO, 3, 1, art_pkg::RS_UNREGISTER, 0,
			64'hAAAA, 0), 1, mk_out(1, 3, art_pkg::RS_UNREGISTER, 0, 64'hAAAA, 1));
		add_row(mk_req(art_pkg::OP_LOOKUP, ALL1, ALL1, 1, 1, art_pkg::RS_GC, 0, 0, 0), 0,
			NONE);
		add_row(mk_req(art_pkg::OP_LOOKUP, ALL1, ALL1, 0, 1, art_pkg::RS_GC, 0, 0, 0), 0,
			NONE);
		add_row(mk_req(art_pkg::OP_ADD, A1_HI, A1_LO, 0, 1, art_pkg::RS_GC, 7, 64'h1234, 0),
			0, NONE);
		add_row(mk_req(art_pkg::OP_PURGE_ADDR, A1_HI, A1_LO, 0, 0, art_pkg::RS_GC, 0, 0, 0),
			0, NONE);
		add_row(mk_req(art_pkg::OP_LOOKUP, A1_HI, A1_LO, 2, 1, art_pkg::RS_GC, 0, 0, 0), 0,
			NONE);
		add_row(mk_req(art_pkg::OP_PURGE_ADDR, A1_HI, A1_LO, 2, 1, art_pkg::RS_GC, 0, 0, 0),
			0, NONE);
		add_row(mk_req(art_pkg::OP_COUNT, 0, 0, 3, 1, art_pkg::RS_GC, 0, 0, 0), 0, NONE);
		for (int i = 0; i < 6; i++)
			add_row(mk_req(art_pkg::OP_ADD, {$urandom, $urandom}, {$urandom, $urandom},
				2'(i % 4), 1, (i % 2) ? art_pkg::RS_REGISTERED : art_pkg::RS_GC,
				16'($urandom), {$urandom, $urandom}, 0), 0, NONE);
		add_row(mk_req(art_pkg::OP_ADD, A1_HI, A1_LO, 1, 1, art_pkg::RS_REGISTERED,
			16'h00FF, ALL1, 0), 0, NONE);
		add_row(mk_req(art_pkg::OP_PURGE_RTR, 0, 0, 0, 1, art_pkg::RS_GC, 0, 0, 0), 0, NONE);
		add_row(mk_req(art_pkg::OP_REMOVE, 0, 0, 1, 1, art_pkg::RS_GC, 0, 0, 1), 0, NONE);

		// Hold reset, then release it
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows
		foreach (vectors[i])
			issue(vectors[i].req, vectors[i].typed, vectors[i].want, pick_gap());
		drain();

		addr_pool[0] = '0;
		addr_pool[1] = {ALL1, ALL1};
		addr_pool[2] = {A1_HI, A1_LO};
		for (int i = 3; i < 6; i++)
			addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};

		// Random phases, each under its own lifetime setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_cfg(art_pkg::REG_GC_LIFETIME, 16'h0000);
					write_cfg(art_pkg::REG_TENT_LIFETIME, 16'hFFFF);
				end
				1: begin
					write_cfg(art_pkg::REG_GC_LIFETIME, 16'hFFFF);
					write_cfg(art_pkg::REG_TENT_LIFETIME, 16'h0000);
				end
				default: begin
					write_cfg(art_pkg::REG_GC_LIFETIME, 16'($urandom));
					write_cfg(art_pkg::REG_TENT_LIFETIME, 16'($urandom));
				end
			endcase
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) begin
				no_idle = (((sent - phase_start) / 40) % 3 == 2);
				if (ph == 2 && sent - phase_start >= 140 && sent - phase_start < 143)
					drain();
				if (ph == 3 && sent - phase_start >= 150 && sent - phase_start < 153) begin
					no_idle = 1'b0;
					wrap_counter();
				end
				if ($urandom_range(0, 99) < 60)
					run_session();
				else begin
					q = random_request();
					send(q);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("PASS address_registration_table");
		else
			$display("FAIL address_registration_table");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/art_pkg.sv
hw/rtl/art_ram.sv
hw/rtl/art_match.sv
hw/rtl/art_seq.sv
hw/rtl/address_registration_table.sv
tb/tb_top.sv
